// ===== hdl/led_bps_pkg.sv =====
package led_bps_pkg;

  // Input word kind, carried on tuser
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] REG_PATTERN_ZERO   = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_PATTERN_ONE    = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_PATTERN_TWO    = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_REPEAT_PATTERN = 3'd3;

  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned SlotBits    = 16;
  localparam int unsigned RepeatBits  = 8;
  localparam int unsigned SelBits     = 2;
  localparam int unsigned NumPatterns = 4;

  // Pattern used for every replay
  localparam logic [SelBits-1:0] REPEAT_SEL = 2'd3;

  typedef struct packed {
    logic                   we;
    logic [CfgIdxBits-1:0]  idx;
    logic [CfgDataBits-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [SelBits-1:0]    sel;
    logic [RepeatBits-1:0] rep;
  } item_t;

  typedef struct packed {
    logic led;
    logic busy;
    logic fin;
  } result_t;

endpackage

// ===== hdl/led_bps_core.sv =====
module led_bps_core #(
  parameter int unsigned STEPS         = 4,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  led_bps_pkg::cfg_wr_t cfg_i,
  input  logic                 push_i,
  input  led_bps_pkg::item_t   item_i,
  output led_bps_pkg::result_t res_o
);
  import led_bps_pkg::*;

  localparam int unsigned SW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [DURATION_BITS-1:0] DurMax = {DURATION_BITS{1'b1}};
  localparam logic [SW:0] StepsW = (SW+1)'(STEPS);

  logic [DURATION_BITS-1:0] pat_q [NumPatterns][STEPS];

  logic                     running_q, running_d;
  logic                     led_q, led_d;
  logic [SelBits-1:0]       active_q, active_d;
  logic [SW-1:0]            step_q, step_d;
  logic [DURATION_BITS-1:0] elapsed_q, elapsed_d;
  logic [RepeatBits-1:0]    reps_q, reps_d;
  logic                     fin;

  logic [DURATION_BITS-1:0] elapsed_inc;
  logic [DURATION_BITS-1:0] dur_cur;
  logic [DURATION_BITS-1:0] dur_next;
  logic [SW:0]              next_step;
  logic                     next_end;

  // Only the low DURATION_BITS of each 16-bit slot are kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPatterns; p++) begin
        for (int s = 0; s < STEPS; s++) begin
          pat_q[p][s] <= '0;
        end
      end
    end else if (cfg_i.we && (cfg_i.idx <= REG_REPEAT_PATTERN)) begin
      for (int s = 0; s < STEPS; s++) begin
        pat_q[cfg_i.idx[SelBits-1:0]][s] <= cfg_i.data[SlotBits*s +: DURATION_BITS];
      end
    end
  end

  assign elapsed_inc = (elapsed_q < DurMax) ? elapsed_q + 1'b1 : elapsed_q;
  assign dur_cur     = pat_q[active_q][step_q];
  assign next_step   = {1'b0, step_q} + 1'b1;
  assign dur_next    = (next_step < StepsW) ? pat_q[active_q][next_step[SW-1:0]] : '0;
  assign next_end    = (next_step >= StepsW) || (dur_next == '0);

  always_comb begin
    running_d = running_q;
    led_d     = led_q;
    active_d  = active_q;
    step_d    = step_q;
    elapsed_d = elapsed_q;
    reps_d    = reps_q;
    fin       = 1'b0;
    if (item_i.cmd == CMD_START) begin
      running_d = 1'b1;
      led_d     = 1'b1;
      active_d  = item_i.sel;
      step_d    = '0;
      elapsed_d = '0;
      reps_d    = item_i.rep;
    end else if (running_q) begin
      elapsed_d = elapsed_inc;
      if (elapsed_inc >= dur_cur) begin
        elapsed_d = '0;
        if (next_end) begin
          if (reps_q != '0) begin
            // replay: relight and start the repeat pattern
            reps_d   = reps_q - 1'b1;
            led_d    = 1'b1;
            active_d = REPEAT_SEL;
            step_d   = '0;
          end else begin
            led_d     = 1'b0;
            running_d = 1'b0;
            step_d    = '0;
            fin       = 1'b1;
          end
        end else begin
          step_d = next_step[SW-1:0];
          led_d  = ~led_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      led_q     <= 1'b0;
      active_q  <= '0;
      step_q    <= '0;
      elapsed_q <= '0;
      reps_q    <= '0;
    end else if (push_i) begin
      running_q <= running_d;
      led_q     <= led_d;
      active_q  <= active_d;
      step_q    <= step_d;
      elapsed_q <= elapsed_d;
      reps_q    <= reps_d;
    end
  end

  assign res_o.led  = led_d;
  assign res_o.busy = running_d;
  assign res_o.fin  = fin;

endmodule

// ===== hdl/led_blink_pattern_sequencer_top.sv =====
// Each result word is registered in the output register, or in the skid register on a stall.
// Throughput: one word per cycle while skid is empty; update and result share one combinational pass.
// A two-entry output stage (register plus skid) keeps input flowing for one stalled result.
// Reset: rst_ni is asynchronous, active low; clears sequencer state, patterns and output valid flags.
module led_blink_pattern_sequencer_top #(
  parameter int unsigned STEPS         = 4,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [led_bps_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [led_bps_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [15:0]                          s_axis_tdata,  // [1:0] pattern_select, [9:2] repeat_count
  input  logic                                 s_axis_tuser,  // [0] cmd
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [0] led_level, [1] busy_res
  output logic                                 m_axis_tlast   // finished
);
  import led_bps_pkg::*;

  cfg_wr_t cfg;
  item_t   item;
  result_t res;
  logic    push, pop;

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  assign item.cmd = cmd_e'(s_axis_tuser);
  assign item.sel = s_axis_tdata[SelBits-1:0];
  assign item.rep = s_axis_tdata[SelBits +: RepeatBits];

  assign s_axis_tready = !skid_valid_q;
  assign push = s_axis_tvalid && s_axis_tready;
  assign pop  = out_valid_q && m_axis_tready;

  led_bps_core #(
    .STEPS         (STEPS),
    .DURATION_BITS (DURATION_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .push_i (push),
    .item_i (item),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.busy, out_q.led};
  assign m_axis_tlast  = out_q.fin;

  // skid holds a word only behind a pending output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");

  // the sequence-end word reports idle
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tdata[1])
    else $error("finished while busy");

  // LED is lit only while a pattern plays
  a_led_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
    else $error("LED lit while idle");

  // a start word taken into a free output register yields a lit, busy, unfinished result next cycle
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && s_axis_tuser && (!out_valid_q || pop)) |=>
      (m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[1] && !m_axis_tlast))
    else $error("bad start result");

endmodule

// ===== tb/led_blink_pattern_sequencer_top_tb.sv =====
module led_blink_pattern_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import led_bps_pkg::*;

  localparam int unsigned Steps    = 4;
  localparam int unsigned DurBits  = 16;
  localparam int unsigned Limit    = 1_000_000;
  localparam int unsigned LongStep = 64;
  localparam logic [DurBits-1:0] DurMax = '1;

  localparam logic [CfgIdxBits-1:0] RegIdx [NumPatterns] = '{
    REG_PATTERN_ZERO, REG_PATTERN_ONE, REG_PATTERN_TWO, REG_REPEAT_PATTERN
  };

  typedef struct packed {
    cmd_e                  cmd;
    logic [SelBits-1:0]    sel;
    logic [RepeatBits-1:0] rep;
    logic                  typed;
    result_t               want;
  } dir_row_t;

  localparam int unsigned NumRows = 23;
  // patterns for this table: 0 = {1,2}, 1 = {0,1}, 2 = {3,1,1,1}, repeat = all zero
  localparam dir_row_t DirRows [NumRows] = '{
    '{CMD_TICK,  2'd0, 8'd0,   1'b1, 3'b000},  // tick while idle
    '{CMD_START, 2'd0, 8'd0,   1'b1, 3'b110},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},  // list ends on zero, finished
    '{CMD_TICK,  2'd3, 8'd255, 1'b1, 3'b000},
    '{CMD_START, 2'd1, 8'd2,   1'b1, 3'b110},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},  // zero first duration
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},  // empty repeat pattern eats a repeat
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_START, 2'd2, 8'd255, 1'b1, 3'b110},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},  // runs off the end of the list
    '{CMD_START, 2'd3, 8'd0,   1'b1, 3'b110},  // restart while running
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000},
    '{CMD_START, 2'd0, 8'd255, 1'b1, 3'b110},
    '{CMD_START, 2'd3, 8'd255, 1'b1, 3'b110},
    '{CMD_TICK,  2'd0, 8'd0,   1'b0, 3'b000}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic                   s_valid = 1'b0;
  logic [15:0]            s_data = '0;
  logic                   s_user = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [7:0]             m_data;
  logic                   m_last;

  led_blink_pattern_sequencer_top #(
    .STEPS        (Steps),
    .DURATION_BITS(DurBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [CfgDataBits-1:0] pattern_regs [NumPatterns];
  logic                   seq_running;
  logic                   seq_led;
  logic [SelBits-1:0]     seq_pat;
  logic [2:0]             seq_step;
  logic [DurBits-1:0]     seq_elapsed;
  logic [RepeatBits-1:0]  seq_repeats;

  result_t     status_due_q [$];
  result_t     got;
  result_t     want;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic logic [DurBits-1:0] step_duration(logic [SelBits-1:0] pat,
                                                       int unsigned step);
    if (step >= Steps) return '0;
    return pattern_regs[pat][SlotBits*step +: DurBits];
  endfunction

  function automatic void start_pattern(logic [SelBits-1:0] pat);
    seq_running = 1'b1;
    seq_led     = 1'b1;
    seq_pat     = pat;
    seq_step    = '0;
    seq_elapsed = '0;
  endfunction

  function automatic result_t advance_sequencer(cmd_e cmd, logic [SelBits-1:0] sel,
                                                logic [RepeatBits-1:0] rep);
    result_t     r;
    int unsigned nxt;
    r.fin = 1'b0;
    if (cmd == CMD_START) begin
      start_pattern(sel);
      seq_repeats = rep;
    end else if (seq_running) begin
      if (seq_elapsed != DurMax) seq_elapsed++;
      if (seq_elapsed >= step_duration(seq_pat, seq_step)) begin
        nxt = seq_step + 1;
        seq_elapsed = '0;
        if (nxt >= Steps || step_duration(seq_pat, nxt) == '0) begin
          seq_led = 1'b0;
          if (seq_repeats != '0) begin
            seq_repeats--;
            start_pattern(REPEAT_SEL);
          end else begin
            seq_running = 1'b0;
            seq_step    = '0;
            r.fin       = 1'b1;
          end
        end else begin
          seq_step = nxt[2:0];
          seq_led  = ~seq_led;
        end
      end
    end
    r.led  = seq_led;
    r.busy = seq_running;
    return r;
  endfunction

  function automatic logic [CfgDataBits-1:0] random_pattern();
    logic [CfgDataBits-1:0] p;
    int unsigned            roll;
    p = '0;
    for (int s = 0; s < Steps; s++) begin
      roll = $urandom_range(99);
      p[SlotBits*s +: SlotBits] = roll < 15 ? 16'd0 :
                                  roll < 85 ? 16'($urandom_range(1, 4)) :
                                              16'($urandom_range(5, 12));
    end
    return p;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // one word on the slave side, with random idle cycles ahead of it
  task automatic send_word(cmd_e cmd, logic [SelBits-1:0] sel, logic [RepeatBits-1:0] rep,
                           logic typed, result_t typed_res);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {6'b0, rep, sel};
    do @(posedge clk_i); while (!s_ready);
    r = advance_sequencer(cmd, sel, rep);
    status_due_q.push_back(typed ? typed_res : r);
  endtask

  task automatic send_random_word();
    cmd_e                  cmd;
    logic [RepeatBits-1:0] rep;
    int unsigned           roll;
    roll = $urandom_range(99);
    cmd  = (seq_running ? roll < 6 : roll < 80) ? CMD_START : CMD_TICK;
    roll = $urandom_range(99);
    rep  = roll < 55 ? 8'd0 : roll < 90 ? 8'($urandom_range(1, 3)) : 8'($urandom_range(255));
    send_word(cmd, SelBits'($urandom_range(3)), rep, 1'b0, '0);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    s_valid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_patterns(logic [CfgDataBits-1:0] p0, logic [CfgDataBits-1:0] p1,
                               logic [CfgDataBits-1:0] p2, logic [CfgDataBits-1:0] p3);
    logic [CfgDataBits-1:0] vals [NumPatterns];
    vals = '{p0, p1, p2, p3};
    for (int i = 0; i < NumPatterns; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= RegIdx[i];
      cfg_data <= vals[i];
      pattern_regs[i] = vals[i];
      @(posedge clk_i);
    end
    // out-of-range index must be dropped
    cfg_idx  <= REG_REPEAT_PATTERN + CfgIdxBits'($urandom_range(1, 4));
    cfg_data <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i) m_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_n && m_valid && m_ready) begin
      got = '{led: m_data[0], busy: m_data[1], fin: m_last};
      if (status_due_q.size() == 0) begin
        flag_error($sformatf("unexpected result word led=%b busy=%b fin=%b",
                             got.led, got.busy, got.fin));
      end else begin
        want = status_due_q.pop_front();
        if (got != want)
          flag_error($sformatf("led/busy/fin expected %b/%b/%b, got %b/%b/%b",
                               want.led, want.busy, want.fin, got.led, got.busy, got.fin));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == Limit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NumPatterns; i++) pattern_regs[i] = '0;
    seq_running = 1'b0;
    seq_led     = 1'b0;
    seq_pat     = '0;
    seq_step    = '0;
    seq_elapsed = '0;
    seq_repeats = '0;

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    load_patterns(64'h0000_0000_0002_0001, 64'h0000_0000_0001_0000,
                  64'h0001_0001_0001_0003, 64'h0);
    for (int i = 0; i < NumRows; i++)
      send_word(DirRows[i].cmd, DirRows[i].sel, DirRows[i].rep,
                DirRows[i].typed, DirRows[i].want);
    drain();

    // idling mixes: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 20 : 0;
      stall_pct = (ph == 2) ? 59 : (ph == 3) ? 20 : 0;
      load_patterns(random_pattern(), random_pattern(), random_pattern(), random_pattern());
      for (int n = 0; n < 240; n++) begin
        if (n == 120) drain();
        send_random_word();
      end
      drain();
    end

    // one long step, then the list ends
    idle_pct  = 0;
    stall_pct = 0;
    load_patterns(64'(LongStep), '1, '1, '1);
    send_word(CMD_START, 2'd0, 8'd0, 1'b0, '0);
    repeat (LongStep + 2) send_word(CMD_TICK, 2'd0, 8'd0, 1'b0, '0);
    drain();

    // every pattern empty
    idle_pct  = 20;
    stall_pct = 20;
    load_patterns('0, '0, '0, '0);
    repeat (60) send_random_word();
    drain();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && status_due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/led_bps_pkg.sv
hdl/led_bps_core.sv
hdl/led_blink_pattern_sequencer_top.sv
tb/led_blink_pattern_sequencer_top_tb.sv
